// ===== hw/rtl/bbrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Box blur package
// Shared constants, register codes and types of the box blur block.
// ----------------------------------------------------------------------------
package bbrs_pkg;

    localparam int CH_W      = 16;
    localparam int NUM_CH    = 3;
    localparam int PIX_W     = CH_W * NUM_CH;
    localparam int DIM_W     = 11;
    localparam int RAD_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam int JOB_COL_W  = 12;
    localparam int JOB_SLOT_W = 6;
    localparam int JOB_CNT_W  = 6;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [RAD_W-1:0] RADIUS_RST = 4'd2;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd1024;

    typedef struct packed {
        logic [JOB_SLOT_W-1:0] slot;
        logic [JOB_SLOT_W-1:0] last_slot;
        logic [JOB_CNT_W-1:0]  nrows;
        logic [JOB_COL_W-1:0]  x0;
        logic [JOB_CNT_W-1:0]  ncols;
        logic                  frame_end;
    } job_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } result_t;

    typedef enum logic [6:0] {
        B_IDLE  = 7'b0000001,
        B_SETUP = 7'b0000010,
        B_READ  = 7'b0000100,
        B_LAST  = 7'b0001000,
        B_ROUND = 7'b0010000,
        B_DIV   = 7'b0100000,
        B_PUSH  = 7'b1000000
    } back_state_t;

endpackage

// ===== hw/rtl/bbrs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module bbrs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bbrs_front.sv =====
// ----------------------------------------------------------------------------
// Box blur front end
// Holds the configuration, stores pixels and issues one window job per result.
// ----------------------------------------------------------------------------
module bbrs_front import bbrs_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 8
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_valid,
    input  logic [CFG_IDX_W-1:0]                       cfg_index,
    input  logic [DIM_W-1:0]                           cfg_data,
    input  logic                                       item_acc,
    input  logic                                       command,
    input  logic [CH_W-1:0]                            in_red,
    input  logic [CH_W-1:0]                            in_green,
    input  logic [CH_W-1:0]                            in_blue,
    output logic                                       wr_en,
    output logic [$clog2(2*MAX_RADIUS+1)+$clog2(MAX_WIDTH)-1:0] wr_addr,
    output logic [PIX_W-1:0]                           wr_data,
    output logic                                       job_push,
    output job_t                                       job
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int ROWS  = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(ROWS);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int ROW_W = DIM_W + 1;
    localparam int XW    = ((CW > DIM_W) ? CW : DIM_W) + 1;

    logic [RAD_W-1:0] radius_reg;
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [CW-1:0]    in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [DIM_W-1:0] out_row_reg, out_row_next;
    logic [SW-1:0]    in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;

    logic             cfg_hit;
    logic [DIM_W-1:0] w_eff, h_eff, lim;
    logic [RW-1:0]    rad_sat, r_eff;
    logic [SW-1:0]    last_slot;
    logic             pix_phase, ignore, step, emit, lag_done, in_col_last, out_col_last;
    logic             frame_end;
    logic [ROW_W-1:0] oy, ry, dy, y0, y1, yend;
    logic [XW-1:0]    ox, rx, dx, x0, x1, xend;
    logic [SW:0]      slot0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign cfg_hit = cfg_valid &&
                     (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH ||
                      cfg_index == REG_HEIGHT);

    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        h_eff   = (height_reg == '0) ? DIM_W'(1) : height_reg;
        lim     = (w_eff >= DIM_W'(2)) ? ((w_eff - DIM_W'(2)) >> 1) : '0;
        rad_sat = (32'(radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_reg);
        r_eff   = (DIM_W'(rad_sat) > lim) ? RW'(lim) : rad_sat;
    end

    assign last_slot = SW'({r_eff, 1'b0});

    assign pix_phase = in_row_reg < ROW_W'(h_eff);
    assign ignore    = pix_phase && (command == CMD_DRAIN);
    assign step      = item_acc && !ignore;
    assign lag_done  = (in_row_reg > ROW_W'(r_eff)) ||
                       ((in_row_reg == ROW_W'(r_eff)) && (XW'(in_col_reg) >= XW'(r_eff)));
    assign emit      = step && lag_done;

    assign in_col_last  = XW'(in_col_reg) == (XW'(w_eff) - XW'(1));
    assign out_col_last = XW'(out_col_reg) == (XW'(w_eff) - XW'(1));
    assign frame_end    = out_col_last && (out_row_reg == (h_eff - DIM_W'(1)));

    always_comb
    begin
        oy    = ROW_W'(out_row_reg);
        ry    = ROW_W'(r_eff);
        dy    = (oy > ry) ? ry : oy;
        y0    = oy - dy;
        yend  = oy + ry;
        y1    = (yend < ROW_W'(h_eff)) ? yend : (ROW_W'(h_eff) - ROW_W'(1));
        ox    = XW'(out_col_reg);
        rx    = XW'(r_eff);
        dx    = (ox > rx) ? rx : ox;
        x0    = ox - dx;
        xend  = ox + rx;
        x1    = (xend < XW'(w_eff)) ? xend : (XW'(w_eff) - XW'(1));
        if ({1'b0, out_slot_reg} >= (SW+1)'(dy))
            slot0 = {1'b0, out_slot_reg} - (SW+1)'(dy);
        else
            slot0 = {1'b0, out_slot_reg} + {1'b0, last_slot} + (SW+1)'(1) - (SW+1)'(dy);
    end

    always_comb
    begin
        job.slot      = JOB_SLOT_W'(slot0);
        job.last_slot = JOB_SLOT_W'(last_slot);
        job.nrows     = JOB_CNT_W'(y1 - y0 + ROW_W'(1));
        job.x0        = JOB_COL_W'(x0);
        job.ncols     = JOB_CNT_W'(x1 - x0 + XW'(1));
        job.frame_end = frame_end;
    end

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        if (cfg_hit || (emit && frame_end))
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
        end
        else if (step)
        begin
            if (in_col_last)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + ROW_W'(1);
                in_slot_next = (in_slot_reg == last_slot) ? '0 : in_slot_reg + SW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (emit)
            begin
                if (out_col_last)
                begin
                    out_col_next  = '0;
                    out_row_next  = out_row_reg + DIM_W'(1);
                    out_slot_next = (out_slot_reg == last_slot) ? '0 : out_slot_reg + SW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
        end
    end

    assign wr_en    = item_acc && pix_phase && (command == CMD_PIXEL);
    assign wr_addr  = {in_slot_reg, in_col_reg};
    assign wr_data  = {in_red, in_green, in_blue};
    assign job_push = emit;

endmodule

// ===== hw/rtl/bbrs_back.sv =====
// ----------------------------------------------------------------------------
// Box blur back end
// Walks one clipped window through the line store, sums it and divides by area.
// ----------------------------------------------------------------------------
module bbrs_back import bbrs_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 8
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       job_valid,
    input  job_t                                       job,
    output logic                                       job_pop,
    output logic                                       busy,
    output logic                                       rd_en,
    output logic [$clog2(2*MAX_RADIUS+1)+$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic [PIX_W-1:0]                           rd_data,
    output logic                                       res_valid,
    input  logic                                       res_ready,
    output result_t                                    res
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int ROWS = 2 * MAX_RADIUS + 1;
    localparam int SW   = $clog2(ROWS);
    localparam int CNTW = $clog2(ROWS + 1);
    localparam int AW   = 2 * CNTW;
    localparam int SUMW = CH_W + AW + 1;
    localparam int DCW  = $clog2(SUMW + 1);

    back_state_t      state_reg, state_next;
    logic [CW-1:0]    col_reg, col_next, x0_reg, x0_next;
    logic [SW-1:0]    slot_reg, slot_next, last_slot_reg, last_slot_next;
    logic [CNTW-1:0]  rcnt_reg, rcnt_next, ccnt_reg, ccnt_next;
    logic [CNTW-1:0]  nrows_reg, nrows_next, ncols_reg, ncols_next;
    logic             fe_reg, fe_next, rd_vld_reg, rd_vld_next;
    logic [AW-1:0]    area_reg, area_next;
    logic [DCW-1:0]   cnt_reg, cnt_next;
    logic [SUMW-1:0]  acc_reg [NUM_CH];
    logic [SUMW-1:0]  acc_next [NUM_CH];
    logic [AW-1:0]    rem_reg [NUM_CH];
    logic [AW-1:0]    rem_next [NUM_CH];
    logic [AW:0]      rem_sh [NUM_CH];
    logic [SUMW-1:0]  acc_add [NUM_CH];

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            acc_add[c] = acc_reg[c] + SUMW'(rd_data[(NUM_CH-1-c)*CH_W +: CH_W]);
            rem_sh[c]  = {rem_reg[c], acc_reg[c][SUMW-1]};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        x0_next        = x0_reg;
        slot_next      = slot_reg;
        last_slot_next = last_slot_reg;
        rcnt_next      = rcnt_reg;
        ccnt_next      = ccnt_reg;
        nrows_next     = nrows_reg;
        ncols_next     = ncols_reg;
        fe_next        = fe_reg;
        area_next      = area_reg;
        cnt_next       = cnt_reg;
        rd_vld_next    = (state_reg == B_READ);
        job_pop        = 1'b0;
        rd_en          = 1'b0;
        res_valid      = 1'b0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            acc_next[c] = acc_reg[c];
            rem_next[c] = rem_reg[c];
        end
        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop        = 1'b1;
                    col_next       = CW'(job.x0);
                    x0_next        = CW'(job.x0);
                    slot_next      = SW'(job.slot);
                    last_slot_next = SW'(job.last_slot);
                    nrows_next     = CNTW'(job.nrows);
                    ncols_next     = CNTW'(job.ncols);
                    rcnt_next      = CNTW'(job.nrows) - CNTW'(1);
                    ccnt_next      = CNTW'(job.ncols) - CNTW'(1);
                    fe_next        = job.frame_end;
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        acc_next[c] = '0;
                    end
                    state_next = B_SETUP;
                end
            end
            B_SETUP:
            begin
                area_next  = nrows_reg * ncols_reg;
                state_next = B_READ;
            end
            B_READ:
            begin
                rd_en = 1'b1;
                if (rd_vld_reg)
                begin
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        acc_next[c] = acc_add[c];
                    end
                end
                if (ccnt_reg == '0)
                begin
                    if (rcnt_reg == '0)
                    begin
                        state_next = B_LAST;
                    end
                    else
                    begin
                        col_next  = x0_reg;
                        ccnt_next = ncols_reg - CNTW'(1);
                        rcnt_next = rcnt_reg - CNTW'(1);
                        slot_next = (slot_reg == last_slot_reg) ? '0 : slot_reg + SW'(1);
                    end
                end
                else
                begin
                    col_next  = col_reg + CW'(1);
                    ccnt_next = ccnt_reg - CNTW'(1);
                end
            end
            B_LAST:
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    acc_next[c] = acc_add[c];
                end
                state_next = B_ROUND;
            end
            B_ROUND:
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    acc_next[c] = acc_reg[c] + SUMW'(area_reg >> 1);
                    rem_next[c] = '0;
                end
                cnt_next   = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    if (rem_sh[c] >= {1'b0, area_reg})
                    begin
                        rem_next[c] = AW'(rem_sh[c] - {1'b0, area_reg});
                        acc_next[c] = {acc_reg[c][SUMW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[c] = AW'(rem_sh[c]);
                        acc_next[c] = {acc_reg[c][SUMW-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + DCW'(1);
                if (cnt_reg == DCW'(SUMW - 1))
                begin
                    state_next = B_PUSH;
                end
            end
            B_PUSH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg       <= col_next;
        x0_reg        <= x0_next;
        slot_reg      <= slot_next;
        last_slot_reg <= last_slot_next;
        rcnt_reg      <= rcnt_next;
        ccnt_reg      <= ccnt_next;
        nrows_reg     <= nrows_next;
        ncols_reg     <= ncols_next;
        fe_reg        <= fe_next;
        area_reg      <= area_next;
        cnt_reg       <= cnt_next;
        for (int c = 0; c < NUM_CH; c++)
        begin
            acc_reg[c] <= acc_next[c];
            rem_reg[c] <= rem_next[c];
        end
    end

    assign busy          = (state_reg != B_IDLE);
    assign rd_addr       = {slot_reg, col_reg};
    assign res.red       = acc_reg[0][CH_W-1:0];
    assign res.green     = acc_reg[1][CH_W-1:0];
    assign res.blue      = acc_reg[2][CH_W-1:0];
    assign res.frame_end = fe_reg;

endmodule

// ===== hw/rtl/box_blur_running_sum.sv =====
// ----------------------------------------------------------------------------
// Box blur, clipped square window mean
// Top level: front end, job queue, window engine, line store and result queue.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and each result is the rounded mean of the
// clipped (2r+1) square window, trailing the input by r rows plus r pixels.
// An item that causes no result leaves the input ready for the next item. An
// item that causes a result keeps the input full while the window engine
// handles it: the engine reads the clipped window from the line store one
// pixel per cycle, runs a one-bit-per-cycle divider over the three channels
// and waits for room in the result queue. Results wait in a two-entry
// queue, so the output side may stall independently.
module box_blur_running_sum import bbrs_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic                 command,
    input  logic [CH_W-1:0]      in_red,
    input  logic [CH_W-1:0]      in_green,
    input  logic [CH_W-1:0]      in_blue,
    output logic                 empty,
    input  logic                 pop,
    output logic [CH_W-1:0]      out_red,
    output logic [CH_W-1:0]      out_green,
    output logic [CH_W-1:0]      out_blue,
    output logic                 frame_end
);

    localparam int ROWS  = 2 * MAX_RADIUS + 1;
    localparam int DEPTH = ROWS * (2 ** $clog2(MAX_WIDTH));
    localparam int ADW   = $clog2(ROWS) + $clog2(MAX_WIDTH);

    logic             item_acc, wr_en, rd_en, job_push, job_pop, back_busy;
    logic             res_valid, res_ready, oq_push, oq_pop;
    logic [ADW-1:0]   wr_addr, rd_addr;
    logic [PIX_W-1:0] wr_data, rd_data;
    job_t             job_in;
    result_t          res;

    job_t             jq_reg [2];
    logic             jq_wp_reg, jq_rp_reg;
    logic [1:0]       jq_cnt_reg;
    result_t          oq_reg [2];
    logic             oq_wp_reg, oq_rp_reg;
    logic [1:0]       oq_cnt_reg;

    assign cfg_ready = 1'b1;
    assign full      = (jq_cnt_reg != 2'd0) || back_busy;
    assign item_acc  = push && !full;

    bbrs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_acc  (item_acc),
        .command   (command),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_push  (job_push),
        .job       (job_in)
    );

    bbrs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bbrs_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (jq_cnt_reg != 2'd0),
        .job       (jq_reg[jq_rp_reg]),
        .job_pop   (job_pop),
        .busy      (back_busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jq_wp_reg  <= 1'b0;
            jq_rp_reg  <= 1'b0;
            jq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (job_push)
            begin
                jq_wp_reg <= !jq_wp_reg;
            end
            if (job_pop)
            begin
                jq_rp_reg <= !jq_rp_reg;
            end
            jq_cnt_reg <= jq_cnt_reg + 2'(job_push) - 2'(job_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_push)
        begin
            jq_reg[jq_wp_reg] <= job_in;
        end
        if (oq_push)
        begin
            oq_reg[oq_wp_reg] <= res;
        end
    end

    assign res_ready = (oq_cnt_reg != 2'd2);
    assign oq_push   = res_valid && res_ready;
    assign empty     = (oq_cnt_reg == 2'd0);
    assign oq_pop    = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wp_reg  <= 1'b0;
            oq_rp_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wp_reg <= !oq_wp_reg;
            end
            if (oq_pop)
            begin
                oq_rp_reg <= !oq_rp_reg;
            end
            oq_cnt_reg <= oq_cnt_reg + 2'(oq_push) - 2'(oq_pop);
        end
    end

    assign out_red   = oq_reg[oq_rp_reg].red;
    assign out_green = oq_reg[oq_rp_reg].green;
    assign out_blue  = oq_reg[oq_rp_reg].blue;
    assign frame_end = oq_reg[oq_rp_reg].frame_end;

    // A new job may only be issued while the window engine is idle, so that
    // later pixels never overwrite rows that a pending window still reads.
    a_job_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (!back_busy && jq_cnt_reg == 2'd0))
        else $error("job issued while the window engine is busy");

    a_job_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
        jq_cnt_reg != 2'd2)
        else $error("job queue holds more than one job");

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (jq_cnt_reg != 2'd0))
        else $error("window engine took a job from an empty queue");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting result item was lost");

endmodule

// ===== sim/box_blur_running_sum_test.sv =====
// ----------------------------------------------------------------------------
// Box blur running sum testbench
// Streams RGB frames through the block under many window and frame sizes.
// A built-in predictor recomputes every clipped window mean directly from the
// pixels of the current frame. Every result popped from the block is checked
// against the oldest predicted one. Both sides of the block idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module box_blur_running_sum_test;
    import bbrs_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int MAX_R      = 8;
    localparam int ITEM_GOAL  = 850;
    localparam int CALM_AFTER = 700;
    localparam int SETTLE     = 400;
    localparam longint LIMIT  = 3000000;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic            cmd;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_item_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            fe;
    } blur_out_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 push;
    logic                 full;
    logic                 command;
    logic [CH_W-1:0]      in_red;
    logic [CH_W-1:0]      in_green;
    logic [CH_W-1:0]      in_blue;
    logic                 empty;
    logic                 pop;
    logic [CH_W-1:0]      out_red;
    logic [CH_W-1:0]      out_green;
    logic [CH_W-1:0]      out_blue;
    logic                 frame_end;

    box_blur_running_sum DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .command   (command),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .empty     (empty),
        .pop       (pop),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .frame_end (frame_end)
    );

    pixel_item_t pending_pixels[$];
    blur_out_t   expected_means[$];
    logic [PIX_W-1:0] frame_pixels[int];

    logic [RAD_W-1:0] cur_radius;
    logic [DIM_W-1:0] cur_width;
    logic [DIM_W-1:0] cur_height;
    int     in_pos;
    int     out_pos;
    int     item_count;
    int     result_count;
    int     frame_count;
    int     error_count;
    int     send_gap;
    int     pop_stall;
    bit     calm;
    bit     in_taken;
    longint cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int eff_width();
        int w;
        w = cur_width;
        if (w == 0) w = 1;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int eff_height();
        return (cur_height == 0) ? 1 : int'(cur_height);
    endfunction

    function automatic int eff_radius(int w);
        int r;
        int lim;
        r = cur_radius;
        if (r > MAX_R) r = MAX_R;
        lim = (w >= 2) ? (w - 2) / 2 : 0;
        if (r > lim) r = lim;
        return r;
    endfunction

    function automatic void blur_step(pixel_item_t it);
        int w, h, r, total, lag, p, q, oy, ox, y0, y1, x0, x1, area;
        longint s_red, s_green, s_blue;
        logic [PIX_W-1:0] px;
        blur_out_t o;
        w = eff_width();
        h = eff_height();
        r = eff_radius(w);
        total = w * h;
        lag = r * w + r;
        p = in_pos;
        if (p < total)
        begin
            if (it.cmd == CMD_DRAIN) return;
            frame_pixels[p] = {it.red, it.green, it.blue};
        end
        in_pos = p + 1;
        if (p < lag) return;
        q = out_pos;
        oy = q / w;
        ox = q % w;
        y0 = (oy > r) ? oy - r : 0;
        y1 = (oy + r < h) ? oy + r : h - 1;
        x0 = (ox > r) ? ox - r : 0;
        x1 = (ox + r < w) ? ox + r : w - 1;
        s_red = 0;
        s_green = 0;
        s_blue = 0;
        for (int yy = y0; yy <= y1; yy++)
        begin
            for (int xx = x0; xx <= x1; xx++)
            begin
                px = frame_pixels[yy * w + xx];
                s_red   += px[3*CH_W-1:2*CH_W];
                s_green += px[2*CH_W-1:CH_W];
                s_blue  += px[CH_W-1:0];
            end
        end
        area = (y1 - y0 + 1) * (x1 - x0 + 1);
        o.red   = CH_W'((s_red + area / 2) / area);
        o.green = CH_W'((s_green + area / 2) / area);
        o.blue  = CH_W'((s_blue + area / 2) / area);
        if (q + 1 >= total)
        begin
            o.fe = 1'b1;
            in_pos = 0;
            out_pos = 0;
        end
        else
        begin
            o.fe = 1'b0;
            out_pos = q + 1;
        end
        expected_means.push_back(o);
    endfunction

    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic pixel_item_t rand_pixel(logic cmd);
        pixel_item_t it;
        it.cmd   = cmd;
        it.red   = rand_channel();
        it.green = rand_channel();
        it.blue  = rand_channel();
        return it;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_RADIUS: cur_radius = val[RAD_W-1:0];
            REG_WIDTH:  cur_width  = val;
            REG_HEIGHT: cur_height = val;
            default: ;
        endcase
        if (idx == REG_RADIUS || idx == REG_WIDTH || idx == REG_HEIGHT)
        begin
            in_pos = 0;
            out_pos = 0;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(int radius, int width, int height);
        write_reg(REG_RADIUS, {(DIM_W-RAD_W)'($urandom), RAD_W'(radius)});
        write_reg(REG_WIDTH, DIM_W'(width));
        write_reg(REG_HEIGHT, DIM_W'(height));
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() != 0 || push || expected_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic queue_frame(bit partial);
        int w, h, r, n, lag;
        w = eff_width();
        h = eff_height();
        r = eff_radius(w);
        n = w * h;
        lag = r * w + r;
        if (partial) n = $urandom_range(1, (n < 40) ? n : 40);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                pending_pixels.push_back(rand_pixel(CMD_DRAIN));
                item_count++;
            end
            pending_pixels.push_back(rand_pixel(CMD_PIXEL));
            item_count++;
        end
        if (!partial)
        begin
            for (int i = 0; i < lag; i++)
            begin
                pending_pixels.push_back(rand_pixel(logic'($urandom_range(0, 1))));
                item_count++;
            end
            frame_count++;
        end
    endtask

    // Driver: feeds the next pending item once the previous one has been taken.
    always @(negedge clk)
    begin : drive_pixels
        logic next_push;
        pixel_item_t it;
        next_push = push;
        if (rst_n && (!push || in_taken))
        begin
            next_push = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (!calm && $urandom_range(0, 19) == 0)
                send_gap = $urandom_range(1, 16) - 1;
            else if (pending_pixels.size() != 0)
            begin
                it = pending_pixels.pop_front();
                next_push = 1'b1;
                command  <= it.cmd;
                in_red   <= it.red;
                in_green <= it.green;
                in_blue  <= it.blue;
            end
        end
        push <= next_push;
    end

    always @(negedge clk)
    begin : drive_pop
        logic next_pop;
        next_pop = 1'b1;
        if (pop_stall > 0)
        begin
            pop_stall--;
            next_pop = 1'b0;
        end
        else if (!calm && $urandom_range(0, 14) == 0)
        begin
            pop_stall = $urandom_range(1, 16) - 1;
            next_pop = 1'b0;
        end
        pop <= rst_n ? next_pop : 1'b0;
    end

    // Monitor: predicts on each accepted item and checks each popped result.
    always @(posedge clk)
    begin : watch_ports
        blur_out_t e;
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        in_taken <= rst_n && push && !full;
        if (rst_n && push && !full)
            blur_step('{command, in_red, in_green, in_blue});
        if (rst_n && pop && !empty)
        begin
            result_count++;
            if (expected_means.size() == 0)
            begin
                $display("%0t: unexpected result r=%h g=%h b=%h fe=%b", $time,
                         out_red, out_green, out_blue, frame_end);
                error_count++;
            end
            else
            begin
                e = expected_means.pop_front();
                if (out_red !== e.red)
                begin
                    $display("%0t: red expected %h actual %h", $time, e.red, out_red);
                    error_count++;
                end
                if (out_green !== e.green)
                begin
                    $display("%0t: green expected %h actual %h", $time, e.green, out_green);
                    error_count++;
                end
                if (out_blue !== e.blue)
                begin
                    $display("%0t: blue expected %h actual %h", $time, e.blue, out_blue);
                    error_count++;
                end
                if (frame_end !== e.fe)
                begin
                    $display("%0t: frame_end expected %b actual %b", $time, e.fe, frame_end);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_RADIUS;
        cfg_data = '0;
        push = 1'b0;
        pop = 1'b0;
        command = CMD_PIXEL;
        in_red = '0;
        in_green = '0;
        in_blue = '0;
        cur_radius = RADIUS_RST;
        cur_width = WIDTH_RST;
        cur_height = HEIGHT_RST;
        in_pos = 0;
        out_pos = 0;
        item_count = 0;
        result_count = 0;
        frame_count = 0;
        error_count = 0;
        send_gap = 0;
        pop_stall = 0;
        calm = 1'b0;
        in_taken = 1'b0;
        cycle_count = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frame: extreme pixels, an early drain, and pixels past the end.
        set_frame(1, 5, 4);
        write_reg(REG_NONE, '1);
        pending_pixels.push_back('{CMD_PIXEL, 16'h0000, 16'h0000, 16'h0000});
        pending_pixels.push_back('{CMD_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        pending_pixels.push_back('{CMD_DRAIN, 16'h1234, 16'h5678, 16'h9ABC});
        pending_pixels.push_back('{CMD_PIXEL, 16'h5555, 16'hAAAA, 16'h5555});
        pending_pixels.push_back('{CMD_PIXEL, 16'hAAAA, 16'h5555, 16'hAAAA});
        for (int i = 4; i < 20; i++) pending_pixels.push_back(rand_pixel(CMD_PIXEL));
        pending_pixels.push_back('{CMD_PIXEL, 16'hFFFF, 16'h0000, 16'hFFFF});
        pending_pixels.push_back('{CMD_DRAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        pending_pixels.push_back('{CMD_PIXEL, 16'h0001, 16'h8000, 16'h00FF});
        pnone_fill: for (int i = 0; i < 3; i++) pending_pixels.push_back(rand_pixel(CMD_DRAIN));
        item_count += 27;
        frame_count++;
        wait_idle();

        // Boundary settings: single pixel, saturated radius, clamped width.
        set_frame(0, 0, 0);
        queue_frame(1'b0);
        queue_frame(1'b0);
        wait_idle();
        set_frame(15, 20, 3);
        queue_frame(1'b0);
        wait_idle();
        set_frame(8, 1024, 1);
        queue_frame(1'b1);
        wait_idle();
        set_frame(0, 2047, 0);
        queue_frame(1'b1);
        wait_idle();
        set_frame(2, 3, 1);
        queue_frame(1'b0);
        wait_idle();

        while (item_count < ITEM_GOAL)
        begin
            if (item_count > CALM_AFTER) calm = 1'b1;
            case ($urandom_range(0, 3))
                0: write_reg(REG_RADIUS, DIM_W'($urandom_range(0, 15)));
                1: write_reg(REG_WIDTH, DIM_W'($urandom_range(1, 18)));
                default: set_frame($urandom_range(0, 9), $urandom_range(1, 18),
                                   $urandom_range(0, 6));
            endcase
            if (eff_width() * eff_height() > 80) write_reg(REG_HEIGHT, DIM_W'(2));
            for (int k = $urandom_range(1, 3); k > 0; k--)
                queue_frame($urandom_range(0, 9) == 0);
            wait_idle();
        end

        $display("Ran %0d items over %0d complete frames, %0d results checked.",
                 item_count, frame_count, result_count);
        $display("Covered radius 0 to 15, widths 0 to 2047, heights 0 to 6 and drain items.");
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bbrs_pkg.sv
hw/rtl/bbrs_ram.sv
hw/rtl/bbrs_front.sv
hw/rtl/bbrs_back.sv
hw/rtl/box_blur_running_sum.sv
sim/box_blur_running_sum_test.sv
